@@ rtl/dvc_pkg.sv @@
// Package for the differential vector clock block.
// Holds field widths, operation codes, item kinds and the command type.
// No dependencies.
package dvc_pkg;

    localparam int IDX_W     = 6;
    localparam int IDX_OUT_W = 4;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int LIM_W     = 7;

    localparam logic [OP_W-1:0] OP_INTERNAL   = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND       = 2'd1;
    localparam logic [OP_W-1:0] OP_RECV_START = 2'd2;
    localparam logic [OP_W-1:0] OP_TUPLE      = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef enum logic [1:0] {
        K_TICK,
        K_SEND,
        K_TUPLE,
        K_BAD_TUPLE
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [IDX_W-1:0]      me;
        logic [IDX_W-1:0]      slot;
        logic [IDX_OUT_W-1:0]  tidx;
        logic [VAL_W-1:0]      tval;
    } t_cmd;

endpackage

@@ rtl/dvc_in_if.sv @@
// Request channel of the differential vector clock.
// Carries valid, ready and the request fields; uses no package.
interface dvc_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  neighbor_slot;
    logic [3:0]  tuple_index;
    logic [31:0] tuple_value;

    modport source (output valid, output operation, output neighbor_slot,
                    output tuple_index, output tuple_value, input ready);
    modport sink   (input valid, input operation, input neighbor_slot,
                    input tuple_index, input tuple_value, output ready);

endinterface

@@ rtl/dvc_out_if.sv @@
// Result channel of the differential vector clock.
// Carries valid, ready and the result fields; uses no package.
interface dvc_out_if;

    logic        valid;
    logic        ready;
    logic [3:0]  entry_index;
    logic [31:0] entry_value;
    logic        last_of_run;

    modport source (output valid, output entry_index, output entry_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input entry_index, input entry_value,
                    input last_of_run, output ready);

endinterface

@@ rtl/dvc_front.sv @@
// Front end: accepts requests, classifies them and queues commands.
// Depends on dvc_pkg and dvc_in_if.
module dvc_front #(
    parameter int PROCESSES = 16,
    parameter int NEIGHBORS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dvc_in_if.sink                       i_in,
    input  logic [dvc_pkg::IDX_OUT_W-1:0] i_own_process,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output dvc_pkg::t_cmd                o_cmd
);

    localparam int QD = 2;

    dvc_pkg::t_cmd r_q [QD];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count,  n_count;

    dvc_pkg::t_cmd           cls;
    logic                    enq;
    logic                    deq;
    logic [dvc_pkg::LIM_W-1:0] own_w;
    logic [dvc_pkg::LIM_W-1:0] slot_w;
    logic [dvc_pkg::LIM_W-1:0] tidx_w;

    assign own_w  = dvc_pkg::LIM_W'(i_own_process);
    assign slot_w = dvc_pkg::LIM_W'(i_in.neighbor_slot);
    assign tidx_w = dvc_pkg::LIM_W'(i_in.tuple_index);

    always_comb begin
        cls.me   = (own_w < dvc_pkg::LIM_W'(PROCESSES))
                 ? dvc_pkg::IDX_W'(i_own_process) : dvc_pkg::IDX_W'(PROCESSES - 1);
        cls.slot = (slot_w < dvc_pkg::LIM_W'(NEIGHBORS))
                 ? dvc_pkg::IDX_W'(i_in.neighbor_slot) : dvc_pkg::IDX_W'(NEIGHBORS - 1);
        cls.tidx = i_in.tuple_index;
        cls.tval = i_in.tuple_value;
        unique case (i_in.operation)
            dvc_pkg::OP_INTERNAL,
            dvc_pkg::OP_RECV_START: cls.kind = dvc_pkg::K_TICK;
            dvc_pkg::OP_SEND:       cls.kind = dvc_pkg::K_SEND;
            dvc_pkg::OP_TUPLE:      cls.kind = (tidx_w < dvc_pkg::LIM_W'(PROCESSES))
                                             ? dvc_pkg::K_TUPLE : dvc_pkg::K_BAD_TUPLE;
            default:                cls.kind = dvc_pkg::K_TICK;
        endcase
    end

    assign i_in.ready  = (r_count != 2'(QD));
    assign enq         = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign deq         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = enq ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = deq ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(enq) - 2'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QD))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'(QD)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'(QD) && !i_cmd_ready) |=> (r_count == 2'(QD)))
        else $error("full queue changed without a pop");

endmodule

@@ rtl/dvc_back.sv @@
// Back end: runs queued commands against the clock, last-update and
// last-sent memories and drives the result register. Depends on dvc_pkg and dvc_out_if.
module dvc_back #(
    parameter int PROCESSES = 16,
    parameter int NEIGHBORS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  dvc_pkg::t_cmd i_cmd,
    dvc_out_if.source     o_out
);

    localparam int AW = $clog2(PROCESSES);
    localparam int NW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int VW = dvc_pkg::VAL_W;
    localparam int XW = dvc_pkg::IDX_W;
    localparam int OW = dvc_pkg::IDX_OUT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_TUPLE = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [VW-1:0] cv_mem [PROCESSES];
    logic [VW-1:0] lu_mem [PROCESSES];
    logic [VW-1:0] ls_mem [NEIGHBORS];

    logic [PROCESSES-1:0] r_cv_vld, r_lu_vld;
    logic [NEIGHBORS-1:0] r_ls_vld;

    logic [VW-1:0] r_cva_rd, r_cvb_rd, r_lu_rd, r_ls_rd;
    logic          r_cva_ok, r_cvb_ok, r_lu_ok, r_ls_ok;

    logic [2:0]    r_state, n_state;
    dvc_pkg::t_cmd r_cmd;
    logic [AW-1:0] r_k;
    logic [VW-1:0] r_own_val;
    logic [VW-1:0] r_since;
    logic          r_hold_vld;
    logic [AW-1:0] r_hold_idx;
    logic [VW-1:0] r_hold_val;

    logic          r_out_vld;
    logic [OW-1:0] r_out_idx;
    logic [VW-1:0] r_out_val;
    logic          r_out_last;

    logic          cva_re, cvb_re, lu_re, ls_re;
    logic [AW-1:0] cva_ra, cvb_ra, lu_ra;
    logic [NW-1:0] ls_ra;
    logic          cv_we, lu_we, ls_we;
    logic [AW-1:0] cv_wa, lu_wa;
    logic [NW-1:0] ls_wa;
    logic [VW-1:0] cv_wd, lu_wd, ls_wd;

    logic          push_en, push_last;
    logic [OW-1:0] push_idx;
    logic [VW-1:0] push_val;
    logic          can_push;

    logic          start_scan, scan_step, hold_load, flush_done;

    logic [AW-1:0] q_me, q_tidx, c_me, c_tidx;
    logic [NW-1:0] q_slot;
    logic [XW-1:0] q_tidx_w, c_tidx_w, hold_w, me_w;
    logic [VW-1:0] cva_val, cvb_val, lu_val, ls_val, inc, tup_new;
    logic          raise, sel;

    assign q_me     = i_cmd.me[AW-1:0];
    assign q_slot   = i_cmd.slot[NW-1:0];
    assign q_tidx_w = XW'(i_cmd.tidx);
    assign q_tidx   = q_tidx_w[AW-1:0];
    assign c_me     = r_cmd.me[AW-1:0];
    assign c_tidx_w = XW'(r_cmd.tidx);
    assign c_tidx   = c_tidx_w[AW-1:0];
    assign hold_w   = XW'(r_hold_idx);
    assign me_w     = XW'(c_me);

    assign cva_val = r_cva_ok ? r_cva_rd : '0;
    assign cvb_val = r_cvb_ok ? r_cvb_rd : '0;
    assign lu_val  = r_lu_ok  ? r_lu_rd  : '0;
    assign ls_val  = r_ls_ok  ? r_ls_rd  : '0;

    assign inc     = (cva_val == dvc_pkg::VAL_MAX) ? cva_val : cva_val + VW'(1);
    assign raise   = r_cmd.tval > cva_val;
    assign tup_new = raise ? r_cmd.tval : cva_val;
    assign sel     = (r_k == c_me) || (lu_val > r_since);

    assign can_push = !r_out_vld || o_out.ready;

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        cva_re = 1'b0; cva_ra = q_me;
        cvb_re = 1'b0; cvb_ra = q_me;
        lu_re  = 1'b0; lu_ra  = '0;
        ls_re  = 1'b0; ls_ra  = q_slot;
        cv_we  = 1'b0; cv_wa  = c_me; cv_wd = inc;
        lu_we  = 1'b0; lu_wa  = c_me; lu_wd = inc;
        ls_we  = 1'b0; ls_wa  = r_cmd.slot[NW-1:0]; ls_wd = inc;
        push_en = 1'b0; push_idx = '0; push_val = '0; push_last = 1'b1;
        start_scan = 1'b0; scan_step = 1'b0; hold_load = 1'b0; flush_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == dvc_pkg::K_BAD_TUPLE) begin
                        if (can_push) begin
                            o_cmd_ready = 1'b1;
                            push_en     = 1'b1;
                            push_idx    = i_cmd.tidx;
                        end
                    end else begin
                        o_cmd_ready = 1'b1;
                        cva_re = 1'b1;
                        cva_ra = (i_cmd.kind == dvc_pkg::K_TUPLE) ? q_tidx : q_me;
                        cvb_re = 1'b1;
                        ls_re  = 1'b1;
                        n_state = (i_cmd.kind == dvc_pkg::K_TUPLE) ? S_TUPLE : S_TICK;
                    end
                end
            end
            S_TICK: begin
                if (r_cmd.kind == dvc_pkg::K_SEND) begin
                    cv_we = 1'b1;
                    lu_we = 1'b1;
                    ls_we = 1'b1;
                    cva_re = 1'b1; cva_ra = '0;
                    lu_re  = 1'b1; lu_ra  = '0;
                    start_scan = 1'b1;
                    n_state = S_SCAN;
                end else if (can_push) begin
                    cv_we = 1'b1;
                    lu_we = 1'b1;
                    push_en  = 1'b1;
                    push_idx = me_w[OW-1:0];
                    push_val = inc;
                    n_state  = S_IDLE;
                end
            end
            S_TUPLE: begin
                if (can_push) begin
                    cv_we = raise;
                    cv_wa = c_tidx;
                    cv_wd = r_cmd.tval;
                    lu_we = raise;
                    lu_wa = c_tidx;
                    lu_wd = (c_tidx == c_me) ? r_cmd.tval : cvb_val;
                    push_en  = 1'b1;
                    push_idx = r_cmd.tidx;
                    push_val = tup_new;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(sel && r_hold_vld && !can_push)) begin
                    scan_step = 1'b1;
                    hold_load = sel;
                    if (sel && r_hold_vld) begin
                        push_en   = 1'b1;
                        push_idx  = hold_w[OW-1:0];
                        push_val  = r_hold_val;
                        push_last = 1'b0;
                    end
                    if (r_k == AW'(PROCESSES - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        cva_re = 1'b1; cva_ra = r_k + AW'(1);
                        lu_re  = 1'b1; lu_ra  = r_k + AW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (can_push) begin
                    push_en    = 1'b1;
                    push_idx   = hold_w[OW-1:0];
                    push_val   = r_hold_val;
                    flush_done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cv_we) begin
            cv_mem[cv_wa] <= cv_wd;
        end
        if (cva_re) begin
            r_cva_rd <= cv_mem[cva_ra];
        end
        if (cvb_re) begin
            r_cvb_rd <= cv_mem[cvb_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lu_we) begin
            lu_mem[lu_wa] <= lu_wd;
        end
        if (lu_re) begin
            r_lu_rd <= lu_mem[lu_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            ls_mem[ls_wa] <= ls_wd;
        end
        if (ls_re) begin
            r_ls_rd <= ls_mem[ls_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_vld <= '0;
            r_lu_vld <= '0;
            r_ls_vld <= '0;
            r_cva_ok <= 1'b0;
            r_cvb_ok <= 1'b0;
            r_lu_ok  <= 1'b0;
            r_ls_ok  <= 1'b0;
        end else begin
            if (cva_re) r_cva_ok <= r_cv_vld[cva_ra];
            if (cvb_re) r_cvb_ok <= r_cv_vld[cvb_ra];
            if (lu_re)  r_lu_ok  <= r_lu_vld[lu_ra];
            if (ls_re)  r_ls_ok  <= r_ls_vld[ls_ra];
            if (cv_we)  r_cv_vld[cv_wa] <= 1'b1;
            if (lu_we)  r_lu_vld[lu_wa] <= 1'b1;
            if (ls_we)  r_ls_vld[ls_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_ready) begin
            r_cmd <= i_cmd;
        end
        if (start_scan) begin
            r_own_val <= inc;
            r_since   <= ls_val;
            r_k       <= '0;
        end else if (scan_step) begin
            r_k <= r_k + AW'(1);
        end
        if (hold_load) begin
            r_hold_idx <= r_k;
            r_hold_val <= (r_k == c_me) ? r_own_val : cva_val;
        end
        if (push_en) begin
            r_out_idx  <= push_idx;
            r_out_val  <= push_val;
            r_out_last <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start_scan || flush_done) begin
                r_hold_vld <= 1'b0;
            end else if (hold_load) begin
                r_hold_vld <= 1'b1;
            end
            if (push_en) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.entry_index = r_out_idx;
    assign o_out.entry_value = r_out_val;
    assign o_out.last_of_run = r_out_last;

    a_flush_has_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_hold_vld)
        else $error("flush without a held tuple");

    a_partial_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && !push_last) |-> (r_state == S_SCAN))
        else $error("non-final result outside a scan");

    a_tick_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && $past(r_state) != S_TICK) |-> ($past(r_state) == S_IDLE))
        else $error("tick entered from a busy state");

    a_scan_ends_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_step && r_k == AW'(PROCESSES - 1)) |=>
        (r_state == S_FLUSH))
        else $error("scan did not end in flush");

endmodule

@@ rtl/differential_vector_clock.sv @@
// Differential vector clock, top level. Depends on dvc_pkg, dvc_in_if,
// dvc_out_if, dvc_front and dvc_back.
// Non-send path: front queue, back-end command and read registers, then result register.
// A send scans every clock entry in the back end, one per cycle unless the output stalls.
// The front queue holds requests while the back end is busy; commands start only when idle.
// Reset (synchronous, active low) clears all clock state through per-entry valid bits at once.
module differential_vector_clock #(
    parameter int PROCESSES = 16,
    parameter int NEIGHBORS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dvc_in_if.sink     i_in,
    dvc_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    logic [dvc_pkg::IDX_OUT_W-1:0] r_own_process;
    logic                          cmd_valid;
    logic                          cmd_ready;
    dvc_pkg::t_cmd                 cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_process <= '0;
        end else if (i_cfg_we) begin
            r_own_process <= i_cfg_data;
        end
    end

    dvc_front #(
        .PROCESSES (PROCESSES),
        .NEIGHBORS (NEIGHBORS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_own_process (r_own_process),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_ready   (cmd_ready),
        .o_cmd         (cmd)
    );

    dvc_back #(
        .PROCESSES (PROCESSES),
        .NEIGHBORS (NEIGHBORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out       (o_out)
    );

endmodule
